@@ src/ptds_pkg.sv @@
`default_nettype none

package ptds_pkg;

  // default table geometry
  localparam int MAX_TASKS_DEF   = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int PERIOD_BITS_DEF = 16;

  // fixed widths of the word fields
  localparam int ID_W     = 16;
  localparam int PER_W    = 16;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_COLLECT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_DUE      = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  typedef struct packed {
    req_t               req_type;
    logic [ID_W-1:0]    task_id;
    logic [PER_W-1:0]   period;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    due_id;
    status_t            status;
    logic               last;
    logic [COUNT_W-1:0] task_count;
  } out_word_t;

endpackage

`default_nettype wire

@@ src/periodic_task_due_scheduler.sv @@
// tick walks all slots and emits its word at the last slot
// add and delete stop at the first free or matching slot, or else at the last slot
// collect emits one word per due slot, stopping at the last; one none word if none is due
// a finished word that waits on a stalled output holds the walk
// one request at a time; slots read one per cycle when not stalled, write-back trails it
// reset clears the occupied and due flags and the task count; no clearing pass is needed
`default_nettype none

module periodic_task_due_scheduler
  import ptds_pkg::*;
#(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int DW = ID_BITS + 2 * PERIOD_BITS;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          emit_vld;
  out_word_t     emit_word;
  logic          out_free;

  ptds_slot_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  ptds_seq #(
    .MAX_TASKS   (MAX_TASKS),
    .ID_BITS     (ID_BITS),
    .PERIOD_BITS (PERIOD_BITS),
    .AW          (AW),
    .DW          (DW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .emit_vld  (emit_vld),
    .emit_word (emit_word),
    .out_free  (out_free)
  );

  ptds_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_vld  (emit_vld),
    .emit_word (emit_word),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

@@ src/ptds_slot_mem.sv @@
`default_nettype none

module ptds_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 48
) (
  input  wire logic          clk,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata
);

  logic [DW-1:0] slot_mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem_r[waddr] <= wdata;
    end
    // read data holds while the scan is stalled
    if (re) begin
      rdata_r <= slot_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/ptds_out_buf.sv @@
`default_nettype none

module ptds_out_buf
  import ptds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      emit_vld,
  input  wire out_word_t emit_word,
  output logic           out_free,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      out_valid_r;
  out_word_t out_word_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_vld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld && out_free) begin
      out_word_r <= emit_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

@@ src/ptds_seq.sv @@
`default_nettype none

module ptds_seq
  import ptds_pkg::*;
#(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF,
  parameter int AW          = 4,
  parameter int DW          = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_word_t      in_word,
  output logic               mem_re,
  output logic      [AW-1:0] mem_raddr,
  input  wire logic [DW-1:0] mem_rdata,
  output logic               mem_we,
  output logic      [AW-1:0] mem_waddr,
  output logic      [DW-1:0] mem_wdata,
  output logic               emit_vld,
  output out_word_t          emit_word,
  input  wire logic          out_free
);

  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam logic [AW:0]   RD_END  = (AW + 1)'(MAX_TASKS);
  localparam logic [AW-1:0] IDX_END = AW'(MAX_TASKS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } seq_state_t;

  seq_state_t             state_r, state_nxt;
  req_t                   op_r, op_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [PERIOD_BITS-1:0] per_r, per_nxt;
  logic [AW:0]            rd_idx_r, rd_idx_nxt;
  logic                   ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]          ev_idx_r, ev_idx_nxt;
  logic [MAX_TASKS-1:0]   used_r, used_nxt;
  logic [MAX_TASKS-1:0]   due_r, due_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;

  logic [ID_BITS-1:0]     id_e;
  logic [PERIOD_BITS-1:0] per_e;
  logic [PERIOD_BITS-1:0] cd_e;
  logic [MAX_TASKS-1:0]   ev_onehot;
  logic                   ev_used;
  logic                   ev_due;
  logic                   ev_end;
  logic                   rem_zero;
  logic                   hit;
  logic                   need_emit;
  logic                   finish;
  logic                   go;

  assign id_e      = mem_rdata[DW-1 -: ID_BITS];
  assign per_e     = mem_rdata[2*PERIOD_BITS-1 -: PERIOD_BITS];
  assign cd_e      = mem_rdata[PERIOD_BITS-1:0];
  assign ev_onehot = MAX_TASKS'(1) << ev_idx_r;
  assign ev_used   = used_r[ev_idx_r];
  assign ev_due    = due_r[ev_idx_r];
  assign ev_end    = (ev_idx_r == IDX_END);
  // due slots are cleared as they go out, so what is left lies above this slot
  assign rem_zero  = ((used_r & due_r & ~ev_onehot) == '0);

  always_comb begin
    hit       = 1'b0;
    need_emit = 1'b0;
    finish    = 1'b0;
    unique case (op_r)
      REQ_TICK: begin
        need_emit = ev_end;
        finish    = ev_end;
      end
      REQ_ADD: begin
        hit       = !ev_used;
        need_emit = hit || ev_end;
        finish    = need_emit;
      end
      REQ_DELETE: begin
        hit       = ev_used && (id_e == ID_BITS'(id_r));
        need_emit = hit || ev_end;
        finish    = need_emit;
      end
      REQ_COLLECT: begin
        hit       = ev_used && ev_due;
        need_emit = hit || ev_end;
        finish    = (hit && rem_zero) || (!hit && ev_end);
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  // the eval stage waits when it has a word and the output register is taken
  assign go = !ev_vld_r || !need_emit || out_free;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    per_nxt    = per_r;
    rd_idx_nxt = rd_idx_r;
    ev_vld_nxt = ev_vld_r;
    ev_idx_nxt = ev_idx_r;
    used_nxt   = used_r;
    due_nxt    = due_r;
    cnt_nxt    = cnt_r;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_r[AW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = ev_idx_r;
    mem_wdata  = {id_e, per_e, cd_e};
    emit_vld   = 1'b0;
    emit_word  = '{due_id: id_r, status: ST_OK, last: 1'b1,
                   task_count: COUNT_W'(cnt_r)};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_word.req_type;
          id_nxt     = in_word.task_id;
          per_nxt    = PERIOD_BITS'(in_word.period);
          rd_idx_nxt = '0;
          ev_vld_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (go) begin
          if (ev_vld_r) begin
            emit_vld = need_emit;
            unique case (op_r)
              REQ_TICK: begin
                if (ev_used && (cd_e != '0)) begin
                  mem_we = 1'b1;
                  if (cd_e == PERIOD_BITS'(1)) begin
                    mem_wdata         = {id_e, per_e, per_e};
                    due_nxt[ev_idx_r] = 1'b1;
                  end else begin
                    mem_wdata = {id_e, per_e, cd_e - PERIOD_BITS'(1)};
                  end
                end
              end
              REQ_ADD: begin
                if (hit) begin
                  mem_we             = 1'b1;
                  mem_wdata          = {ID_BITS'(id_r), per_r, per_r};
                  used_nxt[ev_idx_r] = 1'b1;
                  due_nxt[ev_idx_r]  = 1'b0;
                  cnt_nxt            = cnt_r + CNTW'(1);
                  emit_word.task_count = COUNT_W'(cnt_r + CNTW'(1));
                end else begin
                  emit_word.status = ST_FULL;
                end
              end
              REQ_DELETE: begin
                if (hit) begin
                  used_nxt[ev_idx_r] = 1'b0;
                  due_nxt[ev_idx_r]  = 1'b0;
                  cnt_nxt            = cnt_r - CNTW'(1);
                  emit_word.task_count = COUNT_W'(cnt_r - CNTW'(1));
                end else begin
                  emit_word.status = ST_NOTFOUND;
                end
              end
              REQ_COLLECT: begin
                if (hit) begin
                  due_nxt[ev_idx_r] = 1'b0;
                  emit_word.due_id  = ID_W'(id_e);
                  emit_word.status  = ST_DUE;
                  emit_word.last    = rem_zero;
                end else begin
                  emit_word.status = ST_NONE;
                end
              end
              default: begin
                emit_vld = 1'b0;
              end
            endcase
          end

          if (ev_vld_r && finish) begin
            ev_vld_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end else if (rd_idx_r < RD_END) begin
            mem_re     = 1'b1;
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = rd_idx_r[AW-1:0];
            rd_idx_nxt = rd_idx_r + (AW + 1)'(1);
          end else begin
            ev_vld_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ev_vld_r <= 1'b0;
      used_r   <= '0;
      due_r    <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= ev_vld_nxt;
      used_r   <= used_nxt;
      due_r    <= due_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    per_r    <= per_nxt;
    rd_idx_r <= rd_idx_nxt;
    ev_idx_r <= ev_idx_nxt;
  end

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_vld |-> out_free)
    else $error("word emitted while output register is taken");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNTW'($countones(used_r)))
    else $error("task count differs from occupied slots");

  a_due_used: assert property (@(posedge clk) disable iff (!rst_n)
    (due_r & ~used_r) == '0)
    else $error("due flag on a free slot");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same slot");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mem_we && !emit_vld))
    else $error("table activity while idle");

endmodule

`default_nettype wire
